>>> hw/rtl/bcsc_pkg.sv
// shared types and constants for the box collision sides checker
package bcsc_pkg;

   // item kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // coordinate width in bits
   localparam int COORD_W = 16;

   // one input item
   typedef struct packed {
      logic                      kind;
      logic signed [COORD_W-1:0] left_x;
      logic signed [COORD_W-1:0] top_y;
      logic signed [COORD_W-1:0] right_x;
      logic signed [COORD_W-1:0] bottom_y;
   } req_type;

   // one result item
   typedef struct packed {
      logic trigger_hit;
      logic hit_up;
      logic hit_down;
      logic hit_right;
      logic hit_left;
      logic table_full;
   } rsp_type;

   // one stored rectangle or query box
   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_LAST,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_query;
      logic empty;
      logic last;
      logic rsp_free;
   } sts_type;

endpackage

>>> hw/rtl/bcsc_ram.sv
// generic single write port ram with registered read
module bcsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bcsc_ctrl.sv
// sequencing state machine for inserts and table walks
module bcsc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bcsc_pkg::sts_type        sts,
   output bcsc_pkg::cmd_type        cmd
);

   bcsc_pkg::ctrl_state_type state_ff;
   bcsc_pkg::ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd          = '0;
      case (state_ff)
         bcsc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = bcsc_pkg::ST_FINISH;
            end
         end
         bcsc_pkg::ST_WALK: begin
            cmd.rd_en = 1'b1;
            if (sts.last) begin
               state_in = bcsc_pkg::ST_LAST;
            end
         end
         // last read data is compared here
         bcsc_pkg::ST_LAST: begin
            state_in = bcsc_pkg::ST_FINISH;
         end
         bcsc_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = bcsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcsc_pkg::ST_IDLE;
         end
      endcase
      // a query against a non-empty table walks it first
      if (state_ff == bcsc_pkg::ST_IDLE && req_valid && sts.is_query && !sts.empty) begin
         state_in = bcsc_pkg::ST_WALK;
      end
   end

endmodule

>>> hw/rtl/bcsc_dp.sv
// area table, walk index, side comparators and result register
module bcsc_dp #(
   parameter int MAX_AREAS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  bcsc_pkg::req_type   req_data,
   input  bcsc_pkg::cmd_type   cmd,
   output bcsc_pkg::sts_type   sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bcsc_pkg::rsp_type   rsp_data
);

   localparam int IDX_W = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
   localparam int CNT_W = $clog2(MAX_AREAS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_AREAS);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               cmp_en_ff;
   bcsc_pkg::box_type  box_ff;
   bcsc_pkg::box_type  new_box;
   bcsc_pkg::box_type  area;
   logic [bcsc_pkg::BOX_W-1:0] rd_data;
   logic               kind_ff;
   logic               full_ff, full_in;
   logic               trig_ff, up_ff, down_ff, right_ff, left_ff;
   logic               trig_c, up_c, down_c, right_c, left_c;
   logic               wr_en;
   logic               room;
   logic               rsp_valid_ff, rsp_valid_in;
   bcsc_pkg::rsp_type  rsp_ff;

   assign new_box.x1 = req_data.left_x;
   assign new_box.y1 = req_data.top_y;
   assign new_box.x2 = req_data.right_x;
   assign new_box.y2 = req_data.bottom_y;

   // insert write and walk read
   assign room  = (count_ff < CNT_MAX);
   assign wr_en = cmd.accept && (req_data.kind == bcsc_pkg::KIND_INSERT) && room;

   bcsc_ram #(
      .WIDTH (bcsc_pkg::BOX_W),
      .DEPTH (MAX_AREAS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (new_box),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign area = rd_data;

   // fill count and walk index
   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.rd_en) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cmp_en_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // side tests of the query box against the area read last cycle
   always_comb begin
      trig_c  = (box_ff.x1 <= area.x1) && (box_ff.x2 >= area.x1) &&
                (box_ff.y1 <= area.y2) && (box_ff.y2 >= area.y1);
      up_c    = (box_ff.x1 <= area.x2) && (box_ff.x2 >= area.x1) &&
                (box_ff.y1 <= area.y2) && (box_ff.y2 > area.y2) &&
                (box_ff.y1 > area.y1);
      down_c  = (box_ff.x1 <= area.x2) && (box_ff.x2 >= area.x1) &&
                (box_ff.y1 < area.y1) && (box_ff.y2 >= area.y1) &&
                (box_ff.y2 < area.y2);
      right_c = (box_ff.x1 < area.x1) && (box_ff.x2 >= area.x1) &&
                (box_ff.y1 <= area.y2) && (box_ff.y2 >= area.y1) &&
                (box_ff.x2 < area.x2);
      left_c  = (box_ff.x1 <= area.x2) && (box_ff.x2 > area.x2) &&
                (box_ff.y1 <= area.y2) && (box_ff.y2 >= area.y1) &&
                (box_ff.x1 > area.x1);
   end

   // item capture and flag accumulation
   assign full_in = (req_data.kind == bcsc_pkg::KIND_INSERT) && !room;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         box_ff   <= new_box;
         kind_ff  <= req_data.kind;
         full_ff  <= full_in;
         trig_ff  <= 1'b0;
         up_ff    <= 1'b0;
         down_ff  <= 1'b0;
         right_ff <= 1'b0;
         left_ff  <= 1'b0;
      end else if (cmp_en_ff) begin
         trig_ff  <= trig_ff | trig_c;
         up_ff    <= up_ff | up_c;
         down_ff  <= down_ff | down_c;
         right_ff <= right_ff | right_c;
         left_ff  <= left_ff | left_c;
      end
   end

   // result register, free again once its transfer completes
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.trigger_hit <= trig_ff;
         rsp_ff.hit_up      <= up_ff;
         rsp_ff.hit_down    <= down_ff;
         rsp_ff.hit_right   <= right_ff;
         rsp_ff.hit_left    <= left_ff;
         rsp_ff.table_full  <= full_ff && (kind_ff == bcsc_pkg::KIND_INSERT);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status toward the controller
   assign sts.is_query = (req_data.kind == bcsc_pkg::KIND_QUERY);
   assign sts.empty    = (count_ff == '0);
   assign sts.last     = ({{(CNT_W + 1 - IDX_W){1'b0}}, idx_ff} + (CNT_W + 1)'(1))
                         == {1'b0, count_ff};
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

endmodule

>>> hw/rtl/box_collision_sides_checker.sv
// top level of the box collision sides checker
//
// The block keeps a table of up to MAX_AREAS rectangles and answers side
// collision queries against it. Input items arrive on req_valid/req_stall
// with req_data; kind selects insert or query. Each item gives exactly one
// result on rsp_valid/rsp_stall with rsp_data.
// An insert appends its rectangle, or sets table_full when the table holds
// MAX_AREAS rectangles already; its result goes to the output register as
// soon as that register is free. A query reads the stored areas from the
// table ram one entry per cycle through its single read port and compares
// each entry in the following cycle, then loads its result the same way; a
// query against an empty table skips the walk. One item is in work at a
// time: req_stall is low only while the block waits for an item, so the next
// transfer can come only once the last result is loaded into the register.
// Results sit in an output register; when the receiver stalls, the result
// holds there and the finished item waits until the register frees.
// Reset empties the table and drops any item in work or waiting result;
// no clearing pass is needed.
module box_collision_sides_checker #(
   parameter int MAX_AREAS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bcsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bcsc_pkg::rsp_type rsp_data
);

   bcsc_pkg::cmd_type cmd;
   bcsc_pkg::sts_type sts;

   // sequencing
   bcsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table and comparators
   bcsc_dp #(
      .MAX_AREAS (MAX_AREAS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/bcsc_chk.sv
// port level checks for the box collision sides checker
module bcsc_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bcsc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bcsc_pkg::rsp_type rsp_data
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one item in work: busy after each transfer
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input transfer taken while an item is in work");

   // a dropped insert never reports collisions
   a_full_no_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         !(rsp_data.trigger_hit || rsp_data.hit_up || rsp_data.hit_down ||
           rsp_data.hit_right || rsp_data.hit_left))
      else $error("table full flagged together with a collision");

endmodule

bind box_collision_sides_checker bcsc_chk u_bcsc_chk (.*);

>>> tb/tb_box_collision_sides_checker.sv
// testbench for the box collision sides checker: directed table, then random traffic
module tb_box_collision_sides_checker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AREA_MAX    = 16;
   localparam int PLAN_LEN    = 25;
   localparam int RAND_ITEMS  = 950;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 40;

   localparam bcsc_pkg::rsp_type RSP_CLEAR = '0;
   localparam bcsc_pkg::rsp_type RSP_FULL  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   // one row of the directed plan
   typedef struct {
      bcsc_pkg::req_type item;
      bit                typed;
      bcsc_pkg::rsp_type flags;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   bcsc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   bcsc_pkg::rsp_type rsp_data;

   // scoreboard state
   bcsc_pkg::rsp_type flags_due[$];
   bcsc_pkg::rsp_type want;
   bcsc_pkg::box_type area_copy[AREA_MAX];
   int                area_fill = 0;
   int                errors = 0;
   int                cycle_count = 0;
   bit                calm = 1'b0;
   plan_row_type      plan[PLAN_LEN];

   box_collision_sides_checker #(
      .MAX_AREAS(AREA_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver backpressure, quiet during the calm stretch
   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 24);
   end

   // apply one item to the shadow table and work out its flags
   function automatic bcsc_pkg::rsp_type apply_item(input bcsc_pkg::req_type it);
      bcsc_pkg::rsp_type f;
      bcsc_pkg::box_type b;
      bcsc_pkg::box_type a;
      f = RSP_CLEAR;
      b.x1 = it.left_x;
      b.y1 = it.top_y;
      b.x2 = it.right_x;
      b.y2 = it.bottom_y;
      if (it.kind == bcsc_pkg::KIND_INSERT) begin
         if (area_fill < AREA_MAX) begin
            area_copy[area_fill] = b;
            area_fill++;
         end else begin
            f.table_full = 1'b1;
         end
      end else begin
         for (int i = 0; i < area_fill; i++) begin
            a = area_copy[i];
            if (b.x1 <= a.x1 && b.x2 >= a.x1 && b.y1 <= a.y2 && b.y2 >= a.y1)
               f.trigger_hit = 1'b1;
            if (b.x1 <= a.x2 && b.x2 >= a.x1 && b.y1 <= a.y2 && b.y2 > a.y2 &&
                b.y1 > a.y1)
               f.hit_up = 1'b1;
            if (b.x1 <= a.x2 && b.x2 >= a.x1 && b.y1 < a.y1 && b.y2 >= a.y1 &&
                b.y2 < a.y2)
               f.hit_down = 1'b1;
            if (b.x1 < a.x1 && b.x2 >= a.x1 && b.y1 <= a.y2 && b.y2 >= a.y1 &&
                b.x2 < a.x2)
               f.hit_right = 1'b1;
            if (b.x1 <= a.x2 && b.x2 > a.x2 && b.y1 <= a.y2 && b.y2 >= a.y1 &&
                b.x1 > a.x1)
               f.hit_left = 1'b1;
         end
      end
      return f;
   endfunction

   function automatic void check_flag(input string name, input logic e, input logic a);
      if (a !== e) begin
         errors++;
         $display("%0t mismatch %s expected %b actual %b", $time, name, e, a);
      end
   endfunction

   // result checking on every transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flags_due.size() == 0) begin
            errors++;
            $display("%0t unexpected result expected none actual %p", $time, rsp_data);
         end else begin
            want = flags_due.pop_front();
            check_flag("trigger_hit", want.trigger_hit, rsp_data.trigger_hit);
            check_flag("hit_up", want.hit_up, rsp_data.hit_up);
            check_flag("hit_down", want.hit_down, rsp_data.hit_down);
            check_flag("hit_right", want.hit_right, rsp_data.hit_right);
            check_flag("hit_left", want.hit_left, rsp_data.hit_left);
            check_flag("table_full", want.table_full, rsp_data.table_full);
         end
      end
   end

   function automatic plan_row_type make_row(input logic k, input int x1, input int y1,
                                             input int x2, input int y2, input bit typed,
                                             input bcsc_pkg::rsp_type flags);
      plan_row_type r;
      r.item.kind     = k;
      r.item.left_x   = x1[15:0];
      r.item.top_y    = y1[15:0];
      r.item.right_x  = x2[15:0];
      r.item.bottom_y = y2[15:0];
      r.typed         = typed;
      r.flags         = flags;
      return r;
   endfunction

   // coordinate within span of c, clamped to 16-bit range
   function automatic logic signed [15:0] near(input int c, input int span);
      int v;
      v = c + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // one transfer on the request side, with random idle cycles ahead of it
   task automatic send_item(input bcsc_pkg::req_type it, input bit typed,
                            input bcsc_pkg::rsp_type typed_flags);
      bcsc_pkg::rsp_type pred;
      bit done;
      done = 1'b0;
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      while (!done) begin
         @(posedge clock);
         if (!req_stall) done = 1'b1;
      end
      pred = apply_item(it);
      flags_due = {flags_due, (typed ? typed_flags : pred)};
      @(negedge clock);
   endtask

   // hold off the sender until every result is back
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (flags_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      bcsc_pkg::req_type it;
      bcsc_pkg::box_type a;
      int r;
      int span;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;

      // directed plan: empty table, extremes, swapped corners, fill, then overflow
      plan[0]  = make_row(bcsc_pkg::KIND_QUERY, -32768, -32768, -32768, -32768, 1, RSP_CLEAR);
      plan[1]  = make_row(bcsc_pkg::KIND_QUERY, 32767, 32767, 32767, 32767, 1, RSP_CLEAR);
      plan[2]  = make_row(bcsc_pkg::KIND_INSERT, 0, 0, 100, 100, 1, RSP_CLEAR);
      plan[3]  = make_row(bcsc_pkg::KIND_QUERY, -10, -10, 50, 50, 0, RSP_CLEAR);
      plan[4]  = make_row(bcsc_pkg::KIND_QUERY, 50, 50, 150, 150, 0, RSP_CLEAR);
      plan[5]  = make_row(bcsc_pkg::KIND_INSERT, -32768, -32768, 32767, 32767, 1, RSP_CLEAR);
      plan[6]  = make_row(bcsc_pkg::KIND_INSERT, 32767, 32767, -32768, -32768, 1, RSP_CLEAR);
      plan[7]  = make_row(bcsc_pkg::KIND_INSERT, -5, -5, -5, -5, 1, RSP_CLEAR);
      plan[8]  = make_row(bcsc_pkg::KIND_QUERY, -32768, -32768, 32767, 32767, 0, RSP_CLEAR);
      plan[9]  = make_row(bcsc_pkg::KIND_QUERY, 32767, 32767, -32768, -32768, 0, RSP_CLEAR);
      plan[10] = make_row(bcsc_pkg::KIND_INSERT, 200, -300, 260, -200, 1, RSP_CLEAR);
      plan[11] = make_row(bcsc_pkg::KIND_INSERT, -1000, 400, -900, 1000, 1, RSP_CLEAR);
      plan[12] = make_row(bcsc_pkg::KIND_INSERT, 30000, 30000, 32767, 32767, 1, RSP_CLEAR);
      plan[13] = make_row(bcsc_pkg::KIND_INSERT, -32768, -32768, -30000, -30000, 1, RSP_CLEAR);
      plan[14] = make_row(bcsc_pkg::KIND_INSERT, 500, 500, 500, 600, 1, RSP_CLEAR);
      plan[15] = make_row(bcsc_pkg::KIND_INSERT, 700, 700, 800, 700, 1, RSP_CLEAR);
      plan[16] = make_row(bcsc_pkg::KIND_INSERT, -100, 0, 100, 0, 1, RSP_CLEAR);
      plan[17] = make_row(bcsc_pkg::KIND_INSERT, 1, -1, 2, -2, 1, RSP_CLEAR);
      plan[18] = make_row(bcsc_pkg::KIND_INSERT, 4000, -4000, 5000, -3000, 1, RSP_CLEAR);
      plan[19] = make_row(bcsc_pkg::KIND_INSERT, -20000, 15000, -19000, 16000, 1, RSP_CLEAR);
      plan[20] = make_row(bcsc_pkg::KIND_INSERT, 10, 20, 30, 40, 1, RSP_CLEAR);
      plan[21] = make_row(bcsc_pkg::KIND_INSERT, -50, -60, -40, -45, 1, RSP_CLEAR);
      plan[22] = make_row(bcsc_pkg::KIND_INSERT, 123, 456, 789, 1011, 1, RSP_FULL);
      plan[23] = make_row(bcsc_pkg::KIND_QUERY, 190, -310, 210, -250, 0, RSP_CLEAR);
      plan[24] = make_row(bcsc_pkg::KIND_QUERY, -4, -6, -4, -4, 0, RSP_CLEAR);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         send_item(plan[i].item, plan[i].typed, plan[i].flags);
      end
      drain();

      // random traffic: mostly queries aimed at stored areas, some wide noise
      for (int n = 0; n < RAND_ITEMS; n++) begin
         calm = (n >= 300 && n < 450);
         if (n == 600) drain();
         r = $urandom_range(0, 99);
         if (r < 12 || area_fill == 0) begin
            it.kind = bcsc_pkg::KIND_INSERT;
            it.left_x   = 16'($urandom());
            it.top_y    = 16'($urandom());
            it.right_x  = 16'($urandom());
            it.bottom_y = 16'($urandom());
         end else if (r < 32) begin
            it.kind = bcsc_pkg::KIND_QUERY;
            it.left_x   = 16'($urandom());
            it.top_y    = 16'($urandom());
            it.right_x  = 16'($urandom());
            it.bottom_y = 16'($urandom());
         end else begin
            a = area_copy[$urandom_range(0, area_fill - 1)];
            case ($urandom_range(0, 3))
               0: begin
                  span = 1;
               end
               1: begin
                  span = 8;
               end
               2: begin
                  span = 100;
               end
               default: begin
                  span = 3000;
               end
            endcase
            it.kind     = bcsc_pkg::KIND_QUERY;
            it.left_x   = near($urandom_range(0, 1) ? a.x1 : a.x2, span);
            it.top_y    = near($urandom_range(0, 1) ? a.y1 : a.y2, span);
            it.right_x  = near($urandom_range(0, 1) ? a.x1 : a.x2, span);
            it.bottom_y = near($urandom_range(0, 1) ? a.y1 : a.y2, span);
         end
         send_item(it, 1'b0, RSP_CLEAR);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // wait for the last results, then a few more cycles for strays
      while (flags_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (flags_due.size() != 0) begin
         errors++;
         $display("%0t results missing: %0d", $time, flags_due.size());
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
